[rtl/core/utf8d_pkg.sv]
// Shared types and helpers for the UTF-8 byte stream decoder.
// Holds the micro-op format passed from the front end to the back end.
// No dependencies.
`default_nettype none

package utf8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 36;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned BITS_W = 7;
  localparam int unsigned CONT_W = 6;

  // Kind of work one input byte causes in the back end.
  typedef enum logic [1:0] {
    UOP_SINGLE = 2'd0,  // whole symbol in one byte
    UOP_LEAD   = 2'd1,  // lead byte of a multi-byte symbol
    UOP_CONT   = 2'd2,  // continuation byte, more to follow
    UOP_LAST   = 2'd3   // final continuation byte
  } uop_kind_t;

  typedef struct packed {
    uop_kind_t         kind;
    logic [LEN_W-1:0]  len;
    logic [BITS_W-1:0] bits;
  } uop_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Symbol length from a lead byte: leading ones, with 0 or 1 giving 1
  // and all ones capped at 7.
  function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] n;
    begin
      unique casez (b)
        8'b0???????: n = 3'd1;
        8'b10??????: n = 3'd1;
        8'b110?????: n = 3'd2;
        8'b1110????: n = 3'd3;
        8'b11110???: n = 3'd4;
        8'b111110??: n = 3'd5;
        8'b1111110?: n = 3'd6;
        default:     n = 3'd7;
      endcase
      return n;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/utf8_byte_stream_decoder.sv]
// Top level of the permissive UTF-8 byte stream decoder.
// Instantiates utf8d_front, utf8d_queue and utf8d_back; uses utf8d_pkg.
`default_nettype none

// The decoder takes one raw byte per transfer on the input queue and
// delivers one decoded symbol per transfer on the result queue. The
// number of leading ones of a lead byte sets the symbol length (one to
// seven bytes; a byte with zero or one leading ones is a symbol by
// itself and 0xFF counts as a seven-byte lead). Continuation bytes are
// never checked: their low six bits are shifted into a 36-bit value and
// anything above bit 35 is dropped. The decoder sustains one byte per
// clock cycle while in_full is low. A byte that completes a symbol is
// written into the micro-op queue between the front end (which classifies
// bytes) and the back end (which accumulates the value), and reaches the
// output register when the back end takes it, which it does only while
// its output slot is free or being popped. in_full rises only when the
// micro-op queue of QUEUE_DEPTH entries has filled because results are
// not being popped. A symbol that never completes produces no result.
module utf8_byte_stream_decoder import utf8d_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic              in_push,
  output logic                   in_full,
  output logic [CP_W-1:0]        out_code_point,
  output logic [LEN_W-1:0]       out_symbol_bytes,
  output logic                   out_empty,
  input  wire logic              out_pop
);

  uop_t      front_uop;
  uop_t      back_uop;
  q_status_t q_st;
  logic      in_accept;
  logic      q_take;

  assign in_full   = q_st.full;
  assign in_accept = in_push && !q_st.full;

  // The front end only advances its boundary tracking on a transfer.
  utf8d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_i   (in_byte),
    .accept_i (in_accept),
    .uop_o    (front_uop)
  );

  utf8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (in_accept),
    .uop_i    (front_uop),
    .pop_i    (q_take),
    .uop_o    (back_uop),
    .status_o (q_st)
  );

  // The back end drains the queue whenever its output slot is free or
  // is being popped in the same cycle.
  utf8d_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .uop_i          (back_uop),
    .uop_empty_i    (q_st.empty),
    .uop_take_o     (q_take),
    .code_point_o   (out_code_point),
    .symbol_bytes_o (out_symbol_bytes),
    .empty_o        (out_empty),
    .pop_i          (out_pop)
  );

  // The queue can never be full and empty at once.
  assert property (@(posedge clk) disable iff (!rst_n) q_st.full |-> !q_st.empty)
    else $error("micro-op queue reports full and empty together");

  // The back end never takes a micro-op from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_take |-> !q_st.empty)
    else $error("back end took from an empty micro-op queue");

  // An accepted byte is in the queue on the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> !q_st.empty)
    else $error("accepted byte did not reach the micro-op queue");

endmodule

`default_nettype wire

[rtl/core/utf8d_front.sv]
// Front end of the UTF-8 decoder: tracks symbol boundaries and turns
// each accepted byte into a micro-op. Depends on utf8d_pkg.
`default_nettype none

module utf8d_front import utf8d_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [BYTE_W-1:0] byte_i,
  input  wire logic              accept_i,
  output uop_t                   uop_o
);

  logic [LEN_W-1:0] bytes_left_r;
  logic [LEN_W-1:0] bytes_left_nxt;
  logic [LEN_W-1:0] len;
  logic [BYTE_W-1:0] lead_bits;

  always_comb begin
    len       = lead_len(byte_i);
    lead_bits = byte_i & (8'hFF >> len);
    uop_o     = '0;
    if (bytes_left_r == '0) begin
      uop_o.kind     = (len == 3'd1) ? UOP_SINGLE : UOP_LEAD;
      uop_o.len      = len;
      uop_o.bits     = lead_bits[BITS_W-1:0];
      bytes_left_nxt = len - 3'd1;
    end else begin
      uop_o.kind     = (bytes_left_r == 3'd1) ? UOP_LAST : UOP_CONT;
      uop_o.len      = bytes_left_r;
      uop_o.bits     = {1'b0, byte_i[CONT_W-1:0]};
      bytes_left_nxt = bytes_left_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
    end else if (accept_i) begin
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/utf8d_queue.sv]
// Short first-in first-out queue of micro-ops between front and back end.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_queue import utf8d_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_i,
  input  wire uop_t uop_i,
  input  wire logic pop_i,
  output uop_t      uop_o,
  output q_status_t status_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  uop_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign status_o.full  = (count_r == CW'(DEPTH));
  assign status_o.empty = (count_r == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign uop_o          = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= uop_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/utf8d_back.sv]
// Back end of the UTF-8 decoder: accumulates code point bits and holds
// the finished symbol in an output register. Depends on utf8d_pkg.
`default_nettype none

module utf8d_back import utf8d_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire uop_t             uop_i,
  input  wire logic             uop_empty_i,
  output logic                  uop_take_o,
  output logic [CP_W-1:0]       code_point_o,
  output logic [LEN_W-1:0]      symbol_bytes_o,
  output logic                  empty_o,
  input  wire logic             pop_i
);

  logic [CP_W-1:0]  acc_r;
  logic [LEN_W-1:0] len_r;
  logic             out_valid_r;
  logic [CP_W-1:0]  out_cp_r;
  logic [LEN_W-1:0] out_len_r;
  logic             slot_free;
  logic [CP_W-1:0]  acc_shift;

  // The output slot frees up in the same cycle it is popped.
  assign slot_free  = !out_valid_r || pop_i;
  assign uop_take_o = !uop_empty_i && slot_free;
  assign acc_shift  = {acc_r[CP_W-CONT_W-1:0], uop_i.bits[CONT_W-1:0]};

  always_ff @(posedge clk) begin
    if (uop_take_o) begin
      case (uop_i.kind)
        UOP_SINGLE: begin
          out_cp_r  <= CP_W'(uop_i.bits);
          out_len_r <= 3'd1;
        end
        UOP_LEAD: begin
          acc_r <= CP_W'(uop_i.bits);
          len_r <= uop_i.len;
        end
        UOP_CONT: begin
          acc_r <= acc_shift;
        end
        default: begin
          out_cp_r  <= acc_shift;
          out_len_r <= len_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uop_take_o && (uop_i.kind == UOP_SINGLE || uop_i.kind == UOP_LAST)) begin
      out_valid_r <= 1'b1;
    end else if (pop_i) begin
      out_valid_r <= 1'b0;
    end
  end

  assign code_point_o   = out_cp_r;
  assign symbol_bytes_o = out_len_r;
  assign empty_o        = !out_valid_r;

endmodule

`default_nettype wire

[sim/utf8_byte_stream_decoder_test.sv]
// Self-checking testbench for the UTF-8 byte stream decoder: it streams raw bytes
// in and checks every decoded symbol against a cycle-free decoder model of its own.
// Depends on utf8d_pkg and the decoder RTL under rtl/core.
module utf8_byte_stream_decoder_test;
  import utf8d_pkg::*;

  // Size of the random part of the stream, in bytes.
  localparam int unsigned RANDOM_BYTES = 1850;
  // Hard stop for the run.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Cycles to watch the result port after the last expected symbol.
  localparam int unsigned DRAIN_CYCLES = 20;
  // Both sides go idle in about this share of cycles, except in the quiet window.
  localparam int unsigned IDLE_PCT     = 38;
  localparam int unsigned QUIET_FROM   = 2000;
  localparam int unsigned QUIET_TO     = 3500;
  localparam int unsigned MAX_REPORTS  = 10;

  // Byte patterns of the encoding.
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;  // 10xxxxxx continuation
  localparam logic [BYTE_W-1:0] ALL_ONES  = 8'hFF;  // seven-byte lead, one value bit (set)
  localparam logic [BYTE_W-1:0] SEVEN_LEAD = 8'hFE;
  localparam int unsigned       MAX_LEN   = 7;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] nbytes;
  } symbol_t;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              in_push = 1'b0;
  logic              out_pop = 1'b0;
  logic              in_full;
  logic [CP_W-1:0]   out_code_point;
  logic [LEN_W-1:0]  out_symbol_bytes;
  logic              out_empty;

  // Bytes still to be transferred into the decoder, oldest first.
  logic [BYTE_W-1:0] stream_bytes[$];
  // Symbols the decoder owes us, oldest first.
  symbol_t           pending_symbols[$];

  int unsigned bytes_sent     = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned pause_at       = 0;
  bit          pause_done     = 1'b0;

  // Model state: continuation bytes still expected, value so far, and the
  // length of the symbol in progress.
  logic [LEN_W-1:0] conts_left = '0;
  logic [CP_W-1:0]  value_so_far = '0;
  logic [LEN_W-1:0] cur_len = '0;

  utf8_byte_stream_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_byte          (in_byte),
    .in_push          (in_push),
    .in_full          (in_full),
    .out_code_point   (out_code_point),
    .out_symbol_bytes (out_symbol_bytes),
    .out_empty        (out_empty),
    .out_pop          (out_pop)
  );

  always #5 clk = ~clk;

  // Number of leading one bits of a byte, 0 to 8.
  function automatic int unsigned count_lead_ones(input logic [BYTE_W-1:0] b);
    int unsigned n;
    n = 0;
    while (n < BYTE_W && b[BYTE_W-1-n]) n++;
    return n;
  endfunction

  // Advances the decoder model by one byte. Returns 1 when the byte
  // completes a symbol, which is then handed back in sym.
  function bit decode_byte(input logic [BYTE_W-1:0] b, output symbol_t sym);
    int unsigned      n;
    logic [BYTE_W-1:0] kept;
    sym = '0;
    if (conts_left == 0) begin
      // Lead position. Zero or one leading ones make a whole symbol, and
      // all ones is capped at a seven-byte lead.
      n = count_lead_ones(b);
      if (n <= 1) n = 1;
      else if (n > MAX_LEN) n = MAX_LEN;
      kept = b & (ALL_ONES >> n);
      if (n == 1) begin
        sym.code_point = CP_W'(kept);
        sym.nbytes     = LEN_W'(1);
        return 1'b1;
      end
      value_so_far = CP_W'(kept);
      cur_len      = LEN_W'(n);
      conts_left   = LEN_W'(n - 1);
      return 1'b0;
    end
    // Continuation position: the byte is taken unchecked, and bits pushed
    // above the top of the 36-bit value fall away.
    value_so_far = {value_so_far[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
    conts_left   = conts_left - 1'b1;
    if (conts_left != 0) return 1'b0;
    sym.code_point = value_so_far;
    sym.nbytes     = cur_len;
    value_so_far   = '0;
    cur_len        = '0;
    return 1'b1;
  endfunction

  // Every failure but the cycle limit goes through here. Only the first MAX_REPORTS are described.
  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0d: %s", cycle_count, msg);
  endtask

  // Sampling side. Everything is read at the rising edge, before the
  // decoder's registers update, so the values seen are the ones that
  // took part in the transfer at this edge. The result check runs before
  // the model is advanced; a symbol passes through the micro-op queue and
  // the output register, so a byte taken here is never the one popped here.
  always @(posedge clk) begin
    symbol_t want;
    symbol_t got;
    symbol_t made;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else if (rst_n) begin
      if (out_pop && !out_empty) begin
        got.code_point = out_code_point;
        got.nbytes     = out_symbol_bytes;
        if (pending_symbols.size() == 0) begin
          report_error($sformatf("unexpected symbol code_point=%h bytes=%0d",
                                 got.code_point, got.nbytes));
        end else begin
          want = pending_symbols.pop_front();
          if (got.code_point !== want.code_point)
            report_error($sformatf("code_point expected %h got %h",
                                   want.code_point, got.code_point));
          if (got.nbytes !== want.nbytes)
            report_error($sformatf("symbol_bytes expected %0d got %0d",
                                   want.nbytes, got.nbytes));
        end
      end
      if (in_push && !in_full) begin
        void'(stream_bytes.pop_front());
        bytes_sent++;
        if (decode_byte(in_byte, made)) pending_symbols.push_back(made);
      end
    end
  end

  // Driving side. Both handshake inputs change only at the falling edge.
  // The sender offers the oldest untransferred byte unless it idles; it
  // keeps offering the same byte while the decoder reports full. Once,
  // halfway through the stream, the sender holds off until every symbol
  // owed so far has been popped. During the quiet window neither side
  // idles, so the decoder runs at its full rate.
  always @(negedge clk) begin
    bit quiet;
    bit idle_in;
    bit idle_out;
    bit hold;
    quiet    = cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
    idle_in  = !quiet && $urandom_range(99) < IDLE_PCT;
    idle_out = !quiet && $urandom_range(99) < IDLE_PCT;
    hold     = !pause_done && bytes_sent >= pause_at;
    if (hold && pending_symbols.size() == 0) pause_done = 1'b1;
    if (!rst_n) begin
      in_push <= 1'b0;
      out_pop <= 1'b0;
    end else begin
      if (stream_bytes.size() != 0 && !idle_in && !hold) begin
        in_push <= 1'b1;
        in_byte <= stream_bytes[0];
      end else begin
        in_push <= 1'b0;
      end
      out_pop <= !idle_out;
    end
  end

  // Builds the whole stream, runs reset, then waits for the stream to
  // drain and gives the verdict.
  initial begin
    int unsigned       nlen;
    int unsigned       roll;
    int unsigned       total;
    logic [BYTE_W-1:0] b;

    // Directed part: the ASCII extremes, stray continuations, a two-byte
    // symbol at its top value, a three-byte symbol whose continuations
    // look like leads and an all-ones byte, an all-ones lead followed by
    // all-ones continuations (bits shifted out of the value), and a
    // seven-byte lead with mixed continuations.
    stream_bytes = '{8'h00, 8'h7F, CONT_TAG, 8'hBF,
                     8'hDF, 8'hBF,
                     8'hEF, 8'hC0, ALL_ONES,
                     ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                     SEVEN_LEAD, 8'h3F, CONT_TAG, ALL_ONES, 8'hC0, 8'h7F, 8'h01};
    total = stream_bytes.size() + RANDOM_BYTES;

    // Random part: mostly well-formed symbols of every length with random
    // payload, some continuations replaced by arbitrary bytes, and a share
    // of loose random bytes that break the framing.
    while (stream_bytes.size() < total) begin
      roll = $urandom_range(99);
      if (roll < 10) begin
        stream_bytes.push_back(8'($urandom()));
      end else begin
        roll = $urandom_range(99);
        nlen = roll < 25 ? 1 : roll < 50 ? 2 : roll < 70 ? 3 : roll < 82 ? 4 :
               roll < 90 ? 5 : roll < 95 ? 6 : 7;
        if (nlen == 1)
          b = $urandom_range(3) == 0 ? 8'(CONT_TAG | $urandom_range(63))
                                     : 8'($urandom_range(127));
        else if (nlen == MAX_LEN)
          b = $urandom_range(1) ? ALL_ONES : SEVEN_LEAD;
        else
          b = 8'((ALL_ONES << (BYTE_W - nlen)) | ($urandom() & (ALL_ONES >> (nlen + 1))));
        stream_bytes.push_back(b);
        for (int i = 1; i < nlen; i++) begin
          if ($urandom_range(99) < 12) stream_bytes.push_back(8'($urandom()));
          else stream_bytes.push_back(8'(CONT_TAG | $urandom_range(63)));
        end
      end
    end
    pause_at = stream_bytes.size() / 2;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // All bytes transferred and all owed symbols popped; then watch a
    // little longer for symbols that should not exist.
    while (stream_bytes.size() != 0 || pending_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_symbols.size() != 0)
      report_error($sformatf("%0d symbols never arrived", pending_symbols.size()));
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
